>>> rtl/assert_macros.svh
// Assertion helpers used by the weigher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_IMPLIES(label, clock, rst_n, trig, cond) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (trig) |-> (cond)) \
		else $error("assertion failed");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clock, rst_n, trig, cond) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (trig) |=> (cond)) \
		else $error("assertion failed");

`endif

>>> rtl/lctcw_pkg.sv
package lctcw_pkg;

	// Samples summed into one average.
	localparam int SAMPLES = 20;

	// Field and datapath widths.
	localparam int SAMPLE_W = 24;
	localparam int SUM_W    = 30;
	localparam int CNT_W    = 7;
	localparam int DELTA_W  = 25;
	localparam int WEIGHT_W = 32;
	localparam int REF_W    = 16;
	localparam int RUN_W    = 4;
	localparam int PROD_W   = DELTA_W + REF_W;
	localparam int DVD_W    = PROD_W + 4;
	localparam int ITER_W   = 6;
	localparam int AVG_PAD  = DVD_W - SUM_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic        [SUM_W-1:0]    sum_mag_t;
	typedef logic        [CNT_W-1:0]    count_t;
	typedef logic signed [DELTA_W-1:0]  delta_t;
	typedef logic        [DELTA_W-1:0]  delta_mag_t;
	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic        [SAMPLE_W-1:0] thr_t;
	typedef logic        [RUN_W-1:0]    run_t;
	typedef logic        [REF_W-1:0]    ref_t;
	typedef logic        [PROD_W-1:0]   prod_t;
	typedef logic        [DVD_W-1:0]    dvd_t;
	typedef logic        [ITER_W-1:0]   iter_t;
	typedef logic        [1:0]          op_t;
	typedef logic        [1:0]          phase_t;
	typedef logic        [1:0]          cfg_idx_t;

	// Saturation limits on the weight magnitude.
	localparam dvd_t W_NEG_LIM = dvd_t'(64'd1 << (WEIGHT_W - 1));
	localparam dvd_t W_POS_LIM = W_NEG_LIM - dvd_t'(1);

	// Opcodes.
	localparam op_t OP_MEASURE = 2'd0;
	localparam op_t OP_TARE    = 2'd1;
	localparam op_t OP_CAL     = 2'd2;

	// Phase codes on the result.
	localparam phase_t PH_MEASURE = 2'd0;
	localparam phase_t PH_WAIT    = 2'd1;
	localparam phase_t PH_TARE    = 2'd2;
	localparam phase_t PH_CAL     = 2'd3;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
	localparam cfg_idx_t CFG_REQUIRED  = 2'd1;
	localparam cfg_idx_t CFG_REF_GRAMS = 2'd2;

	// Procedure mode.
	typedef enum logic [2:0] {
		MODE_MEASURE    = 3'd0,
		MODE_TARE_FIRST = 3'd1,
		MODE_TARE_WAIT  = 3'd2,
		MODE_TARE_TAKE  = 3'd3,
		MODE_CAL_FIRST  = 3'd4,
		MODE_CAL_WAIT   = 3'd5,
		MODE_CAL_TAKE   = 3'd6
	} mode_t;

	// Sequencer states; nine of them need four bits.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG_DIV,
		ST_AVG_FIX,
		ST_UPDATE,
		ST_DELTA,
		ST_MUL,
		ST_SCALE,
		ST_W_DIV,
		ST_DONE
	} state_t;

endpackage

>>> rtl/load_cell_tare_calibrate_weigher.sv
// A sample that does not close a group is taken with no stall, back to back.
// The sample that closes a group stalls further samples until its result is
// loaded into the output register: one shared bit-serial divider runs 30 steps
// for the average and 45 steps for the weight, skipped while uncalibrated, one
// quotient bit per cycle.
// Reset is asynchronous: control registers take their defaults and a tare starts.
`include "assert_macros.svh"

module load_cell_tare_calibrate_weigher (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  lctcw_pkg::sample_t       sample,
	input  lctcw_pkg::op_t           opcode,
	output logic                     result_valid,
	input  logic                     result_stall,
	output lctcw_pkg::sample_t       raw_average,
	output lctcw_pkg::delta_t        delta,
	output lctcw_pkg::weight_t       weight_tenths,
	output logic                     weight_valid,
	output lctcw_pkg::phase_t        phase,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  lctcw_pkg::cfg_idx_t      cfg_index,
	input  lctcw_pkg::thr_t          cfg_data
);

	lctcw_pkg::state_t     state_q, state_d;
	lctcw_pkg::thr_t       thr_q;
	lctcw_pkg::run_t       req_q;
	lctcw_pkg::ref_t       ref_q;
	lctcw_pkg::sum_t       sum_q;
	lctcw_pkg::count_t     count_q;
	lctcw_pkg::mode_t      mode_q;
	lctcw_pkg::sample_t    prev_q;
	lctcw_pkg::run_t       run_q;
	lctcw_pkg::sample_t    zero_q;
	lctcw_pkg::delta_t     span_q;
	logic                  cal_q;
	lctcw_pkg::sample_t    avg_q;
	lctcw_pkg::delta_t     d_q;
	lctcw_pkg::prod_t      prod_q;
	lctcw_pkg::phase_t     phase_q;
	logic                  neg_q;
	lctcw_pkg::delta_mag_t rem_q;
	lctcw_pkg::dvd_t       dvd_q;
	lctcw_pkg::delta_mag_t dsr_q;
	lctcw_pkg::iter_t      cnt_q;
	logic                  out_valid_q;
	lctcw_pkg::sample_t    out_avg_q;
	lctcw_pkg::delta_t     out_delta_q;
	lctcw_pkg::weight_t    out_weight_q;
	logic                  out_wvalid_q;
	lctcw_pkg::phase_t     out_phase_q;

	logic                  item_fire;
	logic                  is_start;
	lctcw_pkg::sum_t       next_sum;
	lctcw_pkg::count_t     next_cnt;
	logic                  group_done;
	lctcw_pkg::sum_mag_t   sum_mag;
	logic [lctcw_pkg::DELTA_W:0] rem_sh;
	logic [lctcw_pkg::DELTA_W:0] rem_sub;
	logic                  div_ge;
	lctcw_pkg::delta_mag_t rem_nx;
	lctcw_pkg::dvd_t       dvd_nx;
	logic                  div_last;
	lctcw_pkg::sum_mag_t   avg_full;
	lctcw_pkg::delta_t     avg_diff;
	lctcw_pkg::delta_mag_t diff_mag;
	logic                  diff_lt;
	lctcw_pkg::run_t       run_new;
	lctcw_pkg::delta_t     span_new;
	lctcw_pkg::delta_mag_t d_mag;
	lctcw_pkg::delta_mag_t span_mag;
	lctcw_pkg::weight_t    weight_sat;
	logic                  out_load;

	assign cfg_ready     = 1'b1;
	assign result_valid  = out_valid_q;
	assign raw_average   = out_avg_q;
	assign delta         = out_delta_q;
	assign weight_tenths = out_weight_q;
	assign weight_valid  = out_wvalid_q;
	assign phase         = out_phase_q;

	// Group accumulation for the incoming sample; a start opcode drops the partial group.
	always_comb begin
		item_fire  = item_valid && !item_stall;
		is_start   = (opcode == lctcw_pkg::OP_TARE) || (opcode == lctcw_pkg::OP_CAL);
		next_sum   = (is_start ? lctcw_pkg::sum_t'(0) : sum_q) + lctcw_pkg::sum_t'(sample);
		next_cnt   = (is_start ? lctcw_pkg::count_t'(0) : count_q) + lctcw_pkg::count_t'(1);
		group_done = next_cnt == lctcw_pkg::count_t'(lctcw_pkg::SAMPLES);
		sum_mag    = next_sum[lctcw_pkg::SUM_W-1] ? lctcw_pkg::sum_mag_t'(-next_sum)
		                                          : lctcw_pkg::sum_mag_t'(next_sum);
	end

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_sh   = {rem_q, dvd_q[lctcw_pkg::DVD_W-1]};
		rem_sub  = rem_sh - {1'b0, dsr_q};
		div_ge   = rem_sh >= {1'b0, dsr_q};
		rem_nx   = div_ge ? rem_sub[lctcw_pkg::DELTA_W-1:0] : rem_sh[lctcw_pkg::DELTA_W-1:0];
		dvd_nx   = {dvd_q[lctcw_pkg::DVD_W-2:0], div_ge};
		div_last = cnt_q == lctcw_pkg::iter_t'(1);
	end

	// Average sign fix, stability test and span candidate.
	always_comb begin
		avg_full = neg_q ? (~dvd_q[lctcw_pkg::SUM_W-1:0] + lctcw_pkg::sum_mag_t'(1))
		                 : dvd_q[lctcw_pkg::SUM_W-1:0];
		avg_diff = lctcw_pkg::delta_t'(avg_q) - lctcw_pkg::delta_t'(prev_q);
		diff_mag = avg_diff[lctcw_pkg::DELTA_W-1] ? lctcw_pkg::delta_mag_t'(-avg_diff)
		                                          : lctcw_pkg::delta_mag_t'(avg_diff);
		diff_lt  = diff_mag < {1'b0, thr_q};
		run_new  = diff_lt ? (run_q + lctcw_pkg::run_t'(1)) : lctcw_pkg::run_t'(0);
		span_new = lctcw_pkg::delta_t'(avg_q) - lctcw_pkg::delta_t'(zero_q);
		d_mag    = d_q[lctcw_pkg::DELTA_W-1] ? lctcw_pkg::delta_mag_t'(-d_q)
		                                     : lctcw_pkg::delta_mag_t'(d_q);
		span_mag = span_q[lctcw_pkg::DELTA_W-1] ? lctcw_pkg::delta_mag_t'(-span_q)
		                                        : lctcw_pkg::delta_mag_t'(span_q);
	end

	// Weight sign and saturation from the quotient magnitude.
	always_comb begin
		if (!cal_q) begin
			weight_sat = '0;
		end else if (!neg_q) begin
			weight_sat = (dvd_q > lctcw_pkg::W_POS_LIM)
			           ? lctcw_pkg::weight_t'(lctcw_pkg::W_POS_LIM)
			           : lctcw_pkg::weight_t'(dvd_q[lctcw_pkg::WEIGHT_W-1:0]);
		end else begin
			weight_sat = (dvd_q > lctcw_pkg::W_NEG_LIM)
			           ? lctcw_pkg::weight_t'(lctcw_pkg::W_NEG_LIM)
			           : lctcw_pkg::weight_t'(~dvd_q[lctcw_pkg::WEIGHT_W-1:0]
			                                  + lctcw_pkg::weight_t'(1));
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lctcw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and handshake outputs.
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		out_load   = 1'b0;
		unique case (state_q)
			lctcw_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid && group_done) begin
					state_d = lctcw_pkg::ST_AVG_DIV;
				end
			end
			lctcw_pkg::ST_AVG_DIV: begin
				if (div_last) begin
					state_d = lctcw_pkg::ST_AVG_FIX;
				end
			end
			lctcw_pkg::ST_AVG_FIX: begin
				state_d = lctcw_pkg::ST_UPDATE;
			end
			lctcw_pkg::ST_UPDATE: begin
				state_d = lctcw_pkg::ST_DELTA;
			end
			lctcw_pkg::ST_DELTA: begin
				state_d = lctcw_pkg::ST_MUL;
			end
			lctcw_pkg::ST_MUL: begin
				state_d = lctcw_pkg::ST_SCALE;
			end
			lctcw_pkg::ST_SCALE: begin
				state_d = cal_q ? lctcw_pkg::ST_W_DIV : lctcw_pkg::ST_DONE;
			end
			lctcw_pkg::ST_W_DIV: begin
				if (div_last) begin
					state_d = lctcw_pkg::ST_DONE;
				end
			end
			lctcw_pkg::ST_DONE: begin
				out_load = !out_valid_q || !result_stall;
				if (out_load) begin
					state_d = lctcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lctcw_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration registers and procedure state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= lctcw_pkg::thr_t'(2000);
			req_q   <= lctcw_pkg::run_t'(3);
			ref_q   <= lctcw_pkg::ref_t'(1000);
			sum_q   <= '0;
			count_q <= '0;
			mode_q  <= lctcw_pkg::MODE_TARE_FIRST;
			prev_q  <= '0;
			run_q   <= '0;
			zero_q  <= '0;
			span_q  <= '0;
			cal_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lctcw_pkg::CFG_THRESHOLD: thr_q <= cfg_data;
					lctcw_pkg::CFG_REQUIRED:  req_q <= cfg_data[lctcw_pkg::RUN_W-1:0];
					lctcw_pkg::CFG_REF_GRAMS: ref_q <= cfg_data[lctcw_pkg::REF_W-1:0];
					default: ;
				endcase
			end
			if (item_fire) begin
				if (is_start) begin
					run_q  <= '0;
					mode_q <= (opcode == lctcw_pkg::OP_TARE) ? lctcw_pkg::MODE_TARE_FIRST
					                                         : lctcw_pkg::MODE_CAL_FIRST;
				end
				if (group_done) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= next_sum;
					count_q <= next_cnt;
				end
			end
			if (state_q == lctcw_pkg::ST_UPDATE) begin
				unique case (mode_q)
					lctcw_pkg::MODE_TARE_FIRST: begin
						prev_q <= avg_q;
						run_q  <= '0;
						mode_q <= (req_q == '0) ? lctcw_pkg::MODE_TARE_TAKE
						                        : lctcw_pkg::MODE_TARE_WAIT;
					end
					lctcw_pkg::MODE_CAL_FIRST: begin
						prev_q <= avg_q;
						run_q  <= '0;
						mode_q <= (req_q == '0) ? lctcw_pkg::MODE_CAL_TAKE
						                        : lctcw_pkg::MODE_CAL_WAIT;
					end
					lctcw_pkg::MODE_TARE_WAIT: begin
						prev_q <= avg_q;
						run_q  <= run_new;
						if (run_new >= req_q) begin
							mode_q <= lctcw_pkg::MODE_TARE_TAKE;
						end
					end
					lctcw_pkg::MODE_CAL_WAIT: begin
						prev_q <= avg_q;
						run_q  <= run_new;
						if (run_new >= req_q) begin
							mode_q <= lctcw_pkg::MODE_CAL_TAKE;
						end
					end
					lctcw_pkg::MODE_TARE_TAKE: begin
						zero_q <= avg_q;
						mode_q <= lctcw_pkg::MODE_MEASURE;
					end
					lctcw_pkg::MODE_CAL_TAKE: begin
						span_q <= span_new;
						cal_q  <= span_new != '0;
						mode_q <= lctcw_pkg::MODE_MEASURE;
					end
					default: begin
						mode_q <= lctcw_pkg::MODE_MEASURE;
					end
				endcase
			end
		end
	end

	// Datapath and shared divider; no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			lctcw_pkg::ST_IDLE: begin
				if (item_valid && group_done) begin
					dvd_q <= {sum_mag, lctcw_pkg::AVG_PAD'(0)};
					dsr_q <= lctcw_pkg::delta_mag_t'(lctcw_pkg::SAMPLES);
					rem_q <= '0;
					cnt_q <= lctcw_pkg::iter_t'(lctcw_pkg::SUM_W);
					neg_q <= next_sum[lctcw_pkg::SUM_W-1];
				end
			end
			lctcw_pkg::ST_AVG_DIV, lctcw_pkg::ST_W_DIV: begin
				dvd_q <= dvd_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q - lctcw_pkg::iter_t'(1);
			end
			lctcw_pkg::ST_AVG_FIX: begin
				avg_q <= lctcw_pkg::sample_t'(avg_full[lctcw_pkg::SAMPLE_W-1:0]);
			end
			lctcw_pkg::ST_UPDATE: begin
				unique case (mode_q)
					lctcw_pkg::MODE_TARE_TAKE: phase_q <= lctcw_pkg::PH_TARE;
					lctcw_pkg::MODE_CAL_TAKE:  phase_q <= lctcw_pkg::PH_CAL;
					lctcw_pkg::MODE_TARE_FIRST, lctcw_pkg::MODE_TARE_WAIT,
					lctcw_pkg::MODE_CAL_FIRST, lctcw_pkg::MODE_CAL_WAIT:
						phase_q <= lctcw_pkg::PH_WAIT;
					default: phase_q <= lctcw_pkg::PH_MEASURE;
				endcase
			end
			lctcw_pkg::ST_DELTA: begin
				d_q <= lctcw_pkg::delta_t'(avg_q) - lctcw_pkg::delta_t'(zero_q);
			end
			lctcw_pkg::ST_MUL: begin
				prod_q <= lctcw_pkg::prod_t'(d_mag) * lctcw_pkg::prod_t'(ref_q);
				neg_q  <= d_q[lctcw_pkg::DELTA_W-1] ^ span_q[lctcw_pkg::DELTA_W-1];
			end
			lctcw_pkg::ST_SCALE: begin
				// Times ten as two shifted copies.
				dvd_q <= (lctcw_pkg::dvd_t'(prod_q) << 3) + (lctcw_pkg::dvd_t'(prod_q) << 1);
				dsr_q <= span_mag;
				rem_q <= '0;
				cnt_q <= lctcw_pkg::iter_t'(lctcw_pkg::DVD_W);
			end
			default: ;
		endcase
	end

	// Output register, so a new sample can be taken while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q    <= avg_q;
			out_delta_q  <= d_q;
			out_weight_q <= weight_sat;
			out_wvalid_q <= cal_q;
			out_phase_q  <= phase_q;
		end
	end

	`ASSERT_IMPLIES(a_div_count_live, clk, arst_n, (state_q == lctcw_pkg::ST_AVG_DIV) || (state_q == lctcw_pkg::ST_W_DIV), cnt_q != '0)
	`ASSERT_IMPLIES(a_cal_matches_span, clk, arst_n, 1'b1, cal_q == (span_q != '0))
	`ASSERT_IMPLIES(a_count_in_group, clk, arst_n, 1'b1, count_q < lctcw_pkg::count_t'(lctcw_pkg::SAMPLES))
	`ASSERT_IMPLIES(a_uncal_weight_zero, clk, arst_n, result_valid && !weight_valid, weight_tenths == '0)
	`ASSERT_NEXT(a_done_gives_result, clk, arst_n, (state_q == lctcw_pkg::ST_DONE) && out_load, result_valid)

endmodule

>>> sim/weigher_checker.sv
`timescale 1ns / 100ps

module weigher_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic                     item_stall,
	input  lctcw_pkg::sample_t       sample,
	input  lctcw_pkg::op_t           opcode,
	input  logic                     result_valid,
	input  logic                     result_stall,
	input  lctcw_pkg::sample_t       raw_average,
	input  lctcw_pkg::delta_t        delta,
	input  lctcw_pkg::weight_t       weight_tenths,
	input  logic                     weight_valid,
	input  lctcw_pkg::phase_t        phase,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  lctcw_pkg::cfg_idx_t      cfg_index,
	input  lctcw_pkg::thr_t          cfg_data,
	output int                       fail_count,
	output int                       outstanding
);

	import lctcw_pkg::*;

	localparam int     PRINT_LIMIT = 100;
	localparam longint WEIGHT_MAX  = 64'sd2147483647;
	localparam longint WEIGHT_MIN  = -64'sd2147483648;

	// One predicted weighing, field for field as the block reports it.
	typedef struct {
		sample_t raw_average;
		delta_t  delta;
		weight_t weight_tenths;
		logic    weight_valid;
		phase_t  phase;
	} reading_t;

	reading_t expected_readings[$];

	// Register copies.
	thr_t    threshold;
	run_t    required;
	ref_t    grams;

	// Weigher state.
	sum_t    acc_sum;
	int      acc_count;
	mode_t   mode;
	sample_t prev_avg;
	run_t    stable_count;
	sample_t zero_ofs;
	delta_t  span;
	logic    calibrated;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Fold one accepted sample into the group and predict the reading it closes, if any.
	task automatic absorb_sample(input sample_t s, input op_t op);
		longint   avg_l;
		longint   prev_l;
		longint   diff;
		longint   thr_l;
		longint   zo_l;
		longint   d_l;
		longint   g_l;
		longint   sp_l;
		longint   w;
		sample_t  avg;
		phase_t   ph;
		reading_t r;

		// A start opcode drops the partial group and restarts the procedure.
		if (op == OP_TARE || op == OP_CAL) begin
			acc_sum = '0;
			acc_count = 0;
			stable_count = '0;
			if (op == OP_TARE)
				mode = MODE_TARE_FIRST;
			else
				mode = MODE_CAL_FIRST;
		end

		acc_sum = acc_sum + s;
		acc_count++;
		if (acc_count < SAMPLES)
			return;

		avg_l = acc_sum;
		avg_l = avg_l / SAMPLES;
		avg = sample_t'(avg_l);
		acc_sum = '0;
		acc_count = 0;
		ph = PH_MEASURE;

		// Procedure sequencing on each completed average.
		case (mode)
			MODE_TARE_FIRST, MODE_CAL_FIRST: begin
				prev_avg = avg;
				stable_count = '0;
				if (mode == MODE_TARE_FIRST) begin
					if (required == 0)
						mode = MODE_TARE_TAKE;
					else
						mode = MODE_TARE_WAIT;
				end else begin
					if (required == 0)
						mode = MODE_CAL_TAKE;
					else
						mode = MODE_CAL_WAIT;
				end
				ph = PH_WAIT;
			end
			MODE_TARE_WAIT, MODE_CAL_WAIT: begin
				prev_l = prev_avg;
				diff = avg_l - prev_l;
				if (diff < 0)
					diff = -diff;
				thr_l = threshold;
				if (diff < thr_l)
					stable_count = stable_count + run_t'(1);
				else
					stable_count = '0;
				prev_avg = avg;
				if (stable_count >= required) begin
					if (mode == MODE_TARE_WAIT)
						mode = MODE_TARE_TAKE;
					else
						mode = MODE_CAL_TAKE;
				end
				ph = PH_WAIT;
			end
			MODE_TARE_TAKE: begin
				zero_ofs = avg;
				mode = MODE_MEASURE;
				ph = PH_TARE;
			end
			MODE_CAL_TAKE: begin
				zo_l = zero_ofs;
				sp_l = avg_l - zo_l;
				span = delta_t'(sp_l);
				calibrated = (sp_l != 0);
				mode = MODE_MEASURE;
				ph = PH_CAL;
			end
			default: begin
				mode = MODE_MEASURE;
			end
		endcase

		// Delta against the offset as it stands now, then the scaled weight.
		zo_l = zero_ofs;
		d_l = avg_l - zo_l;
		w = 0;
		r.weight_valid = calibrated && (span != 0);
		if (r.weight_valid) begin
			g_l = grams;
			sp_l = span;
			w = (d_l * g_l * 10) / sp_l;
			if (w > WEIGHT_MAX)
				w = WEIGHT_MAX;
			if (w < WEIGHT_MIN)
				w = WEIGHT_MIN;
		end

		r.raw_average = avg;
		r.delta = delta_t'(d_l);
		r.weight_tenths = weight_t'(w);
		r.phase = ph;
		expected_readings.push_back(r);
	endtask

	// Compare one result transfer with the oldest prediction.
	task automatic check_reading();
		reading_t want;

		if (expected_readings.size() == 0) begin
			report_mismatch("raw_average of an unexpected result", raw_average, 0);
		end else begin
			want = expected_readings.pop_front();
			if (raw_average !== want.raw_average)
				report_mismatch("raw_average", raw_average, want.raw_average);
			if (delta !== want.delta)
				report_mismatch("delta", delta, want.delta);
			if (weight_tenths !== want.weight_tenths)
				report_mismatch("weight_tenths", weight_tenths, want.weight_tenths);
			if (weight_valid !== want.weight_valid)
				report_mismatch("weight_valid", weight_valid, want.weight_valid);
			if (phase !== want.phase)
				report_mismatch("phase", phase, want.phase);
		end
	endtask

	// Watch all three channels; a transfer is seen at the edge that takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = thr_t'(2000);
			required = run_t'(3);
			grams = ref_t'(1000);
			acc_sum = '0;
			acc_count = 0;
			mode = MODE_TARE_FIRST;
			prev_avg = '0;
			stable_count = '0;
			zero_ofs = '0;
			span = '0;
			calibrated = 1'b0;
			expected_readings.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_THRESHOLD: threshold = cfg_data;
					CFG_REQUIRED:  required = cfg_data[RUN_W-1:0];
					CFG_REF_GRAMS: grams = cfg_data[REF_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				absorb_sample(sample, opcode);
			if (result_valid && !result_stall)
				check_reading();
			outstanding <= expected_readings.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

	import lctcw_pkg::*;

	localparam int       ITEM_TARGET   = 1250;
	localparam int       SETTLE_CYCLES = 100;
	localparam op_t      OP_SPARE      = 2'd3;
	localparam cfg_idx_t CFG_SPARE     = 2'd3;
	localparam sample_t  S_MAX         = 24'sh7FFFFF;
	localparam sample_t  S_MIN         = 24'sh800000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_stall;
	sample_t  sample = '0;
	op_t      opcode = OP_MEASURE;
	logic     result_valid;
	logic     result_stall = 1'b0;
	sample_t  raw_average;
	delta_t   delta;
	weight_t  weight_tenths;
	logic     weight_valid;
	phase_t   phase;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	cfg_idx_t cfg_index = CFG_THRESHOLD;
	thr_t     cfg_data = '0;

	int       fail_count;
	int       outstanding;
	int       items_sent = 0;
	int       stall_hold = 0;
	bit       no_idle = 1'b0;
	thr_t     cur_thr = thr_t'(2000);
	run_t     cur_need = run_t'(3);
	longint   tare_level = 0;
	bit       tare_exact = 1'b0;

	always #4 clk = ~clk;

	load_cell_tare_calibrate_weigher i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.sample        (sample),
		.opcode        (opcode),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.raw_average   (raw_average),
		.delta         (delta),
		.weight_tenths (weight_tenths),
		.weight_valid  (weight_valid),
		.phase         (phase),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	weigher_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.sample        (sample),
		.opcode        (opcode),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.raw_average   (raw_average),
		.delta         (delta),
		.weight_tenths (weight_tenths),
		.weight_valid  (weight_valid),
		.phase         (phase),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// Hard stop in case the block hangs.
	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic sample_t clamp_sample(input longint v);
		if (v > S_MAX)
			v = S_MAX;
		if (v < S_MIN)
			v = S_MIN;
		return sample_t'(v);
	endfunction

	function automatic longint pick_level();
		sample_t v;
		v = sample_t'($urandom);
		return v;
	endfunction

	// Jitter that mostly stays inside the stability window, sometimes not.
	function automatic longint pick_jitter();
		longint j;
		if (cur_thr == 0)
			j = $urandom_range(0, 50);
		else if ($urandom_range(0, 4) == 0)
			j = cur_thr;
		else
			j = cur_thr / 4;
		if (j > 4194304)
			j = 4194304;
		return j;
	endfunction

	// The receiver stalls for a fresh random count after each result transfer.
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			stall_hold = draw_wait();
		else if (stall_hold > 0)
			stall_hold--;
		result_stall <= (stall_hold > 0);
	end

	// Valid stays high after a transfer; the next call lowers it or reloads the payload.
	task automatic send_item(input sample_t s, input op_t op);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		sample <= s;
		opcode <= op;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic send_group(input longint level, input longint jit, input op_t first_op,
			input int count);
		longint off;
		op_t    op;
		for (int i = 0; i < count; i++) begin
			off = (jit > 0) ? longint'($urandom_range(0, 2 * jit)) - jit : 0;
			if (i == 0)
				op = first_op;
			else
				op = ($urandom_range(0, 15) == 0) ? OP_SPARE : OP_MEASURE;
			send_item(clamp_sample(level + off), op);
		end
	endtask

	// A tare or calibration with enough groups to reach the capture when stable.
	task automatic run_procedure(input op_t kind, input longint level, input longint jit);
		int groups;
		groups = cur_need + 2 + $urandom_range(0, 1);
		send_group(level, jit, kind, SAMPLES);
		for (int g = 1; g < groups; g++)
			send_group(level, jit, OP_MEASURE, SAMPLES);
	endtask

	task automatic run_sequence();
		int     kind;
		int     n;
		longint level;
		longint jit;
		longint span_ofs;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: begin
				level = pick_level();
				jit = ($urandom_range(0, 2) == 0) ? 0 : pick_jitter();
				run_procedure(OP_TARE, level, jit);
				tare_level = level;
				tare_exact = (jit == 0);
			end
			3, 4, 5: begin
				// Small spans push the weight into saturation; zero span leaves it uncalibrated.
				case ($urandom_range(0, 3))
					0: begin
						span_ofs = $urandom_range(1, 20);
						if ($urandom_range(0, 1))
							span_ofs = -span_ofs;
					end
					1: span_ofs = 0;
					default: span_ofs = pick_level();
				endcase
				level = tare_level + span_ofs;
				jit = (tare_exact && span_ofs >= -20 && span_ofs <= 20) ? 0 : pick_jitter();
				run_procedure(OP_CAL, level, jit);
			end
			6: begin
				n = $urandom_range(1, 3);
				repeat (n) send_group(pick_level(), $urandom_range(0, 1 << 20), OP_MEASURE,
					SAMPLES);
			end
			7: begin
				// A procedure cut short by whatever follows.
				send_group(pick_level(), pick_jitter(),
					$urandom_range(0, 1) ? OP_TARE : OP_CAL, $urandom_range(1, 60));
			end
			8: begin
				n = $urandom_range(10, 40);
				repeat (n)
					send_item(sample_t'($urandom),
						($urandom_range(0, 7) == 0) ? op_t'($urandom_range(1, 3)) : OP_MEASURE);
			end
			default: begin
				send_group($urandom_range(0, 1) ? S_MAX : S_MIN, 0, OP_MEASURE, SAMPLES);
			end
		endcase
	endtask

	task automatic write_reg(input cfg_idx_t idx, input thr_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Settings per phase: fixed extremes first, then random picks.
	task automatic configure(input int step);
		thr_t thr;
		run_t need;
		ref_t grams;
		thr_t data;
		case (step)
			0: begin
				thr = '1;
				need = '0;
				grams = '1;
			end
			1: begin
				thr = '0;
				need = run_t'(2);
				grams = ref_t'(1);
			end
			2: begin
				thr = thr_t'(3000);
				need = '1;
				grams = '0;
			end
			3: begin
				thr = thr_t'(1);
				need = run_t'(1);
				grams = ref_t'(1000);
			end
			default: begin
				thr = ($urandom_range(0, 5) == 0) ? thr_t'($urandom)
					: thr_t'($urandom_range(50, 5000));
				need = ($urandom_range(0, 7) == 0) ? run_t'(15) : run_t'($urandom_range(0, 4));
				case ($urandom_range(0, 3))
					0: grams = '1;
					1: grams = ref_t'(1);
					default: grams = ref_t'($urandom);
				endcase
			end
		endcase
		write_reg(CFG_THRESHOLD, thr);
		data = thr_t'($urandom);
		data[RUN_W-1:0] = need;
		write_reg(CFG_REQUIRED, data);
		data = thr_t'($urandom);
		data[REF_W-1:0] = grams;
		write_reg(CFG_REF_GRAMS, data);
		if (step == 1)
			write_reg(CFG_SPARE, thr_t'($urandom));
		cfg_valid <= 1'b0;
		cur_thr = thr;
		cur_need = need;
	endtask

	// Drain every pending result, then give the block time to go idle.
	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int step;
		int seqs;
		step = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-scale samples that average to a truncated zero, the spare
		// opcode, and start opcodes that abort a running procedure.
		for (int i = 0; i < SAMPLES; i++)
			send_item((i % 2) ? S_MIN : S_MAX, (i == 7) ? OP_SPARE : OP_MEASURE);
		send_item(S_MAX, OP_TARE);
		send_item(S_MIN, OP_CAL);
		send_item('0, OP_CAL);
		send_item(sample_t'(-1), OP_TARE);

		// Random phases, each under its own register settings.
		while (items_sent < ITEM_TARGET) begin
			settle();
			configure(step);
			no_idle = ($urandom_range(0, 3) == 0);
			seqs = (cur_need >= 8) ? 2 : 5;
			repeat (seqs) run_sequence();
			step++;
		end

		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> load_cell_tare_calibrate_weigher.f
+incdir+rtl
rtl/lctcw_pkg.sv
rtl/load_cell_tare_calibrate_weigher.sv
sim/weigher_checker.sv
sim/tb.sv
